FILE: hw/rtl/ffha_pkg.sv
// ---------------------------------------------------------------------------
// ffha_pkg: shared types and codes of the first-fit heap allocator
// Command and status bundles between the controller and the datapath, and
// the result status codes.
// ---------------------------------------------------------------------------
package ffha_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BAD_ADDR = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic prev_eval;
    logic alloc_apply;
    logic free_apply;
    logic res_nospace;
    logic res_full;
    logic out_load;
  } ffha_cmd_t;

  typedef struct packed {
    logic in_alloc;
    logic in_skip;
    logic at_end;
    logic hdr_gt;
    logic fits;
    logic padj;
    logic nadj;
    logic full;
  } ffha_stat_t;

endpackage

FILE: hw/rtl/ffha_ram.sv
// ---------------------------------------------------------------------------
// ffha_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read data holds when no
// read is issued.
// ---------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/ffha_ctrl.sv
// ---------------------------------------------------------------------------
// ffha_ctrl: sequencing state machine of the allocator
// Walks the free table one entry per cycle and issues datapath commands.
// ---------------------------------------------------------------------------
module ffha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_valid,
  input  logic               out_ready,
  input  ffha_pkg::ffha_stat_t stat,
  output ffha_pkg::ffha_cmd_t  cmd
);
  import ffha_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_AFIT   = 3'd1;
  localparam logic [2:0] S_FSCAN  = 3'd2;
  localparam logic [2:0] S_FPREV  = 3'd3;
  localparam logic [2:0] S_FAPPLY = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.in_alloc) state_nxt = S_AFIT;
          else if (stat.in_skip) state_nxt = S_DONE;
          else state_nxt = S_FSCAN;
        end
      end
      S_AFIT: begin
        priority if (stat.at_end) begin
          cmd.res_nospace = 1'b1;
          state_nxt       = S_DONE;
        end else if (stat.fits) begin
          cmd.alloc_apply = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FSCAN: begin
        if (!stat.at_end && stat.hdr_gt) cmd.step = 1'b1;
        else state_nxt = S_FPREV;
      end
      S_FPREV: begin
        cmd.prev_eval = 1'b1;
        state_nxt     = S_FAPPLY;
      end
      S_FAPPLY: begin
        if (!stat.padj && !stat.nadj && stat.full) cmd.res_full = 1'b1;
        else cmd.free_apply = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

FILE: hw/rtl/ffha_datapath.sv
// ---------------------------------------------------------------------------
// ffha_datapath: free table, header store and arithmetic of the allocator
// The free table lives in flip-flops and is read through one index pointer;
// block sizes live in a RAM indexed by header address / 8.
// ---------------------------------------------------------------------------
module ffha_datapath #(
  parameter int ARENA_BYTES  = 65536,
  parameter int FREE_ENTRIES = 32,
  parameter int HEADER_BYTES = 16,
  parameter int MIN_BLOCK    = 16,
  parameter int ALIGN_BYTES  = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_opcode,
  input  logic [15:0]          in_request_size,
  input  logic [15:0]          in_block_address,
  input  ffha_pkg::ffha_cmd_t  cmd,
  output ffha_pkg::ffha_stat_t stat,
  output logic [1:0]           res_status,
  output logic [15:0]          res_user_address,
  output logic [15:0]          res_granted_size
);
  import ffha_pkg::*;

  localparam int N     = FREE_ENTRIES;
  localparam int IW    = (N > 1) ? $clog2(N) : 1;
  localparam int PW    = $clog2(N + 1);
  localparam int SLOTS = ARENA_BYTES / 8;
  localparam int HW    = $clog2(SLOTS);
  localparam logic [16:0] ARENA17 = 17'(ARENA_BYTES);
  localparam logic [16:0] HDR17   = 17'(HEADER_BYTES);
  localparam logic [16:0] MIN17   = 17'(MIN_BLOCK);
  localparam logic [16:0] ALM17   = 17'(ALIGN_BYTES - 1);
  localparam logic [16:0] SPLIT17 = 17'(MIN_BLOCK + HEADER_BYTES);
  localparam logic [PW-1:0] NFULL = PW'(N);

  logic [15:0] fs_r [N];
  logic [15:0] fl_r [N];
  logic [15:0] fs_nxt [N];
  logic [15:0] fl_nxt [N];
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] p_r;
  logic          op_r;
  logic [16:0]   sz_r;
  logic [15:0]   hdr_r;
  logic [15:0]   ps_r, pl_r, bs_r;
  logic          pv_r, padj_r;
  logic [17:0]   bl_r;
  logic [1:0]    st_r;
  logic [15:0]   ua_r, gs_r;

  // Entry under the pointer
  logic [15:0] ent_s, ent_l;
  assign ent_s = fs_r[p_r[IW-1:0]];
  assign ent_l = fl_r[p_r[IW-1:0]];

  // Header store
  logic [15:0]   size_rd;
  logic [15:0]   in_hdr;
  logic          hdr_we;
  logic [15:0]   grant;

  assign in_hdr = in_block_address - 16'(HEADER_BYTES);

  ffha_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (ent_s[HW+2:3]),
    .wdata (grant),
    .re    (cmd.load),
    .raddr (in_hdr[HW+2:3]),
    .rdata (size_rd)
  );

  // Input decode
  logic        in_bad;
  logic [16:0] req_min, req_rnd;
  assign in_bad = ({1'b0, in_block_address} < HDR17) ||
                  (({1'b0, in_block_address} - HDR17) >= ARENA17);
  assign req_min = ({1'b0, in_request_size} < MIN17) ? MIN17 : {1'b0, in_request_size};
  assign req_rnd = (req_min + ALM17) & ~ALM17;

  // Allocate arithmetic
  logic [15:0] rem;
  logic        split;
  assign rem   = ent_l - sz_r[15:0];
  assign split = ({1'b0, rem} >= SPLIT17);
  assign grant = split ? sz_r[15:0] : ent_l;
  assign hdr_we = cmd.alloc_apply && ({1'b0, ent_s} < ARENA17);

  // Free arithmetic
  logic [17:0] prev_sum, bl_new;
  logic [18:0] next_sum, mrg;
  logic [15:0] mrg_sat, bl_sat;
  logic        padj_now, nadj;
  assign prev_sum = 18'(ps_r) + 18'(HEADER_BYTES) + 18'(pl_r);
  assign padj_now = pv_r && (prev_sum == 18'(hdr_r));
  assign bl_new   = padj_now ? (18'(pl_r) + 18'(size_rd) + 18'(HEADER_BYTES)) : 18'(size_rd);
  assign next_sum = 19'(bs_r) + 19'(HEADER_BYTES) + 19'(bl_r);
  assign nadj     = !stat.at_end && (next_sum == 19'(ent_s));
  assign mrg      = 19'(bl_r) + 19'(ent_l) + 19'(HEADER_BYTES);
  assign mrg_sat  = (mrg > 19'hFFFF) ? 16'hFFFF : mrg[15:0];
  assign bl_sat   = (bl_r > 18'hFFFF) ? 16'hFFFF : bl_r[15:0];

  always_comb begin
    stat.in_alloc = (in_opcode == OP_ALLOC);
    stat.in_skip  = (in_block_address == 16'd0) || in_bad;
    stat.at_end   = (p_r >= cnt_r);
    stat.hdr_gt   = (hdr_r > ent_s);
    stat.fits     = ({1'b0, ent_l} >= sz_r);
    stat.padj     = padj_r;
    stat.nadj     = nadj;
    stat.full     = (cnt_r >= NFULL);
  end

  // Table update
  always_comb begin
    logic [PW-1:0] kk;
    int            j;
    int            i;
    for (int k = 0; k < N; k++) begin
      fs_nxt[k] = fs_r[k];
      fl_nxt[k] = fl_r[k];
    end
    cnt_nxt = cnt_r;
    for (int k = 0; k < N; k++) begin
      kk = PW'(k);
      j  = (k + 1 < N) ? k + 1 : k;
      i  = (k > 0) ? k - 1 : k;
      if (cmd.alloc_apply) begin
        if (split) begin
          if (kk == p_r) begin
            fs_nxt[k] = hdr_r_alloc(ent_s, sz_r);
            fl_nxt[k] = rem - 16'(HEADER_BYTES);
          end
        end else if (kk >= p_r && kk + 1'b1 < cnt_r) begin
          fs_nxt[k] = fs_r[j];
          fl_nxt[k] = fl_r[j];
        end
      end else if (cmd.free_apply) begin
        if (padj_r) begin
          if (kk + 1'b1 == p_r) fl_nxt[k] = nadj ? mrg_sat : bl_sat;
          if (nadj && kk >= p_r && kk + 1'b1 < cnt_r) begin
            fs_nxt[k] = fs_r[j];
            fl_nxt[k] = fl_r[j];
          end
        end else if (nadj) begin
          if (kk == p_r) begin
            fs_nxt[k] = hdr_r;
            fl_nxt[k] = mrg_sat;
          end
        end else begin
          if (kk == p_r) begin
            fs_nxt[k] = hdr_r;
            fl_nxt[k] = size_rd;
          end else if (kk > p_r && kk <= cnt_r) begin
            fs_nxt[k] = fs_r[i];
            fl_nxt[k] = fl_r[i];
          end
        end
      end
    end
    if (cmd.alloc_apply && !split) cnt_nxt = cnt_r - 1'b1;
    if (cmd.free_apply && padj_r && nadj) cnt_nxt = cnt_r - 1'b1;
    if (cmd.free_apply && !padj_r && !nadj) cnt_nxt = cnt_r + 1'b1;
  end

  function automatic logic [15:0] hdr_r_alloc(input logic [15:0] s, input logic [16:0] z);
    logic [16:0] t;
    t = 17'(s) + HDR17 + z;
    return t[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= PW'(1);
      fs_r[0] <= 16'd0;
      fl_r[0] <= 16'(ARENA_BYTES - HEADER_BYTES);
    end else begin
      cnt_r <= cnt_nxt;
      for (int k = 0; k < N; k++) begin
        fs_r[k] <= fs_nxt[k];
        fl_r[k] <= fl_nxt[k];
      end
    end
  end

  // Item registers and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      sz_r  <= req_rnd;
      hdr_r <= in_hdr;
      p_r   <= '0;
      pv_r  <= 1'b0;
      st_r  <= (in_opcode == OP_FREE && in_block_address != 16'd0 && in_bad) ?
               ST_BAD_ADDR : ST_OK;
      ua_r  <= 16'd0;
      gs_r  <= 16'd0;
    end
    if (cmd.step) begin
      p_r  <= p_r + 1'b1;
      ps_r <= ent_s;
      pl_r <= ent_l;
      pv_r <= 1'b1;
    end
    if (cmd.prev_eval) begin
      padj_r <= padj_now;
      bs_r   <= padj_now ? ps_r : hdr_r;
      bl_r   <= bl_new;
    end
    if (cmd.res_nospace) st_r <= ST_NO_SPACE;
    if (cmd.res_full) st_r <= ST_FULL;
    if (cmd.alloc_apply) begin
      ua_r <= ent_s + 16'(HEADER_BYTES);
      gs_r <= grant;
    end
    if (cmd.free_apply) gs_r <= size_rd;
  end

  assign res_status       = st_r;
  assign res_user_address = ua_r;
  assign res_granted_size = op_r ? gs_r : gs_r;

endmodule

FILE: hw/rtl/first_fit_heap_allocator.sv
// ---------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit allocator with coalescing free list
// Top level joining the controller, the datapath and the result register.
// ---------------------------------------------------------------------------
// Usage notes.
// Each input transaction carries an opcode (allocate or free), a request size
// and a user address. Each one produces exactly one result transaction with a
// status, the granted user address and the granted size.
// An allocate walks the address-ordered free table one entry per cycle until
// the first entry that fits and then loads the result register from its final
// state; a failed allocate examines every entry before it loads its result.
// A free walks the table one entry per cycle to find its place, then decides
// the merge in a previous-neighbour state and an apply state before its final
// state. Null frees and out-of-arena frees go straight to the final state.
// The table scan through the single entry pointer bounds the time of an item,
// and the controller returns to its idle state before the next transaction
// can be accepted.
// One item is in work at a time; in_ready is high only while the controller
// is idle, and the controller leaves its final state only once the result
// register is free.
// If the receiver stalls, the result register holds its transaction and the
// next finished item waits in the controller until the register frees up.
// Reset leaves one free block spanning the arena minus one header; the header
// store holds no meaningful data until blocks have been allocated.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int ARENA_BYTES  = 65536,
  parameter int FREE_ENTRIES = 32,
  parameter int HEADER_BYTES = 16,
  parameter int MIN_BLOCK    = 16,
  parameter int ALIGN_BYTES  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [15:0] in_request_size,
  input  logic [15:0] in_block_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_user_address,
  output logic [15:0] out_granted_size
);
  import ffha_pkg::*;

  ffha_cmd_t  cmd;
  ffha_stat_t stat;
  logic [1:0]  res_status;
  logic [15:0] res_user_address, res_granted_size;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  status_r;
  logic [15:0] ua_r, gs_r;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid_r),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffha_datapath #(
    .ARENA_BYTES  (ARENA_BYTES),
    .FREE_ENTRIES (FREE_ENTRIES),
    .HEADER_BYTES (HEADER_BYTES),
    .MIN_BLOCK    (MIN_BLOCK),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_opcode),
    .in_request_size  (in_request_size),
    .in_block_address (in_block_address),
    .cmd              (cmd),
    .stat             (stat),
    .res_status       (res_status),
    .res_user_address (res_user_address),
    .res_granted_size (res_granted_size)
  );

  // The result register is loaded when the controller finishes an item and
  // emptied when the receiver takes the transaction.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
    if (cmd.out_load) begin
      status_r <= res_status;
      ua_r     <= res_user_address;
      gs_r     <= res_granted_size;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_user_address = ua_r;
  assign out_granted_size = gs_r;

endmodule

FILE: hw/rtl/ffha_checker.sv
// ---------------------------------------------------------------------------
// ffha_checker: port-level assertions for the allocator
// Watches the top-level ports only; attached by a bind statement.
// ---------------------------------------------------------------------------
module ffha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_opcode,
  input logic [15:0] in_request_size,
  input logic [15:0] in_block_address,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_user_address,
  input logic [15:0] out_granted_size
);
  import ffha_pkg::*;

  // A stalled result transaction holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_user_address) &&
    $stable(out_granted_size) && $stable(out_status))
    else $error("result changed while stalled");

  // Failures carry zero fields.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_user_address == 16'd0 &&
    out_granted_size == 16'd0)
    else $error("failed result with nonzero fields");

  // A granted block is never smaller than 8 bytes.
  a_grant_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK && out_user_address != 16'd0 |->
    out_granted_size >= 16'd8)
    else $error("granted block below minimum");

  // One item at a time: the block is busy right after taking a transaction.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted two items back to back");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
